[src/reciprocal_frequency_meter_top_macros.svh]
// assertion macros shared by the frequency meter modules
`ifndef RECIPROCAL_FREQUENCY_METER_TOP_MACROS_SVH
`define RECIPROCAL_FREQUENCY_METER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RFM_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("rfm check failed: same-cycle implication");

// next-cycle implication
`define RFM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("rfm check failed: next-cycle implication");

`else

`define RFM_ASSERT_IMPLY(lbl, ck, rn, ante, cons)

`define RFM_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

[src/rfm_pkg.sv]
`default_nettype none

package rfm_pkg;

    // counter widths
    localparam int TICK_BITS  = 16;
    localparam int WRAP_BITS  = 8;
    localparam int TOTAL_BITS = TICK_BITS + WRAP_BITS;

    // configuration widths and reset values
    localparam int EPW_BITS = 8;
    localparam int N_BITS   = EPW_BITS + 1;
    localparam int CLK_BITS = 26;
    localparam logic [EPW_BITS-1:0] EPW_RESET = 8'd64;
    localparam logic [CLK_BITS-1:0] CLK_RESET = 26'd16000000;

    // clock_hz times ten needs four more bits
    localparam int SCALED_BITS = CLK_BITS + 4;

    // shared divider widths
    localparam int DVD_BITS = (TOTAL_BITS > SCALED_BITS) ? TOTAL_BITS : SCALED_BITS;
    localparam int DVS_BITS = TOTAL_BITS;
    localparam int CNT_BITS = $clog2(DVD_BITS + 1);

    // result
    localparam int FREQ_BITS = 16;
    localparam logic [FREQ_BITS-1:0] FREQ_MAX = {FREQ_BITS{1'b1}};
    localparam logic [WRAP_BITS-1:0] WRAP_MAX = {WRAP_BITS{1'b1}};

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_EDGES_PER_WINDOW = 1'b0,
        REG_CLOCK_HZ         = 1'b1
    } cfg_reg_t;

    // controller to datapath
    typedef struct packed {
        logic div_n_start;
        logic div_f_start;
        logic load_timeout;
        logic load_zero;
        logic load_freq;
        logic push;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic close;
        logic timeout;
        logic div_done;
        logic quot_zero;
        logic out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

[src/rfm_div.sv]
`default_nettype none

`include "reciprocal_frequency_meter_top_macros.svh"

module rfm_div
    import rfm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [DVD_BITS-1:0] dividend,
    input  wire logic [DVS_BITS-1:0] divisor,
    output logic                     busy,
    output logic                     done,
    output logic [DVD_BITS-1:0]      quotient
);

    logic [DVD_BITS-1:0] quot_reg, quot_next;
    logic [DVS_BITS-1:0] rem_reg, rem_next;
    logic [DVS_BITS-1:0] dvs_reg;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [DVS_BITS:0]   trial;
    logic [DVS_BITS:0]   diff;
    logic                fits;

    assign busy     = (cnt_reg != '0);
    assign done     = done_reg;
    assign quotient = quot_reg;

    // one restoring step per cycle, quotient bits shift in from the right
    assign trial = {rem_reg, quot_reg[DVD_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = ~diff[DVS_BITS];

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = busy && (cnt_reg == CNT_BITS'(1));
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = CNT_BITS'(DVD_BITS);
        end
        else if (busy)
        begin
            quot_next = {quot_reg[DVD_BITS-2:0], fits};
            rem_next  = fits ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
            cnt_next  = cnt_reg - 1'b1;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    `RFM_ASSERT_NEXT(a_start_busy, clk, rst_n, start, busy)
    `RFM_ASSERT_IMPLY(a_done_idle, clk, rst_n, done, !busy)
    `RFM_ASSERT_IMPLY(a_rem_below, clk, rst_n, busy, (rem_reg < dvs_reg) || (dvs_reg == '0))

endmodule

`default_nettype wire

[src/rfm_datapath.sv]
`default_nettype none

`include "reciprocal_frequency_meter_top_macros.svh"

module rfm_datapath
    import rfm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_accept,
    input  wire logic                 in_cmd,
    input  wire logic                 in_edge,
    input  wire logic                 cfg_we,
    input  wire cfg_reg_t             cfg_sel,
    input  wire logic [CLK_BITS-1:0]  cfg_value,
    input  wire ctrl_cmd_t            ctrl_cmd,
    output ctrl_status_t              ctrl_status,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic [FREQ_BITS-1:0]      out_freq,
    output logic                      out_no_signal,
    output logic                      out_clipped
);

    logic [EPW_BITS-1:0]   epw_reg;
    logic [CLK_BITS-1:0]   clk_hz_reg;
    logic [TICK_BITS-1:0]  tick_count_reg, tick_count_next;
    logic [WRAP_BITS-1:0]  wrap_count_reg, wrap_count_next;
    logic [EPW_BITS-1:0]   edge_count_reg, edge_count_next;
    logic [TOTAL_BITS-1:0] latched_total_reg, latched_total_next;
    logic                  reported_reg, reported_next;

    logic [TICK_BITS-1:0]  tick_inc;
    logic                  wrap_step;
    logic [WRAP_BITS-1:0]  wrap_new;
    logic                  timeout_now;
    logic                  close_now;
    logic                  tick_event;

    logic [N_BITS-1:0]      n_edges;
    logic [SCALED_BITS-1:0] clk_ext;
    logic [SCALED_BITS-1:0] scaled_hz;
    logic                   div_start;
    logic [DVD_BITS-1:0]    div_dividend;
    logic [DVS_BITS-1:0]    div_divisor;
    logic                   div_busy;
    logic                   div_done;
    logic [DVD_BITS-1:0]    div_quot;
    logic                   quot_over;

    logic [FREQ_BITS-1:0] res_freq_reg;
    logic                 res_no_signal_reg;
    logic                 res_clipped_reg;
    logic                 out_valid_reg;
    logic [FREQ_BITS-1:0] out_freq_reg;
    logic                 out_no_signal_reg;
    logic                 out_clipped_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epw_reg    <= EPW_RESET;
            clk_hz_reg <= CLK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_sel)
                REG_EDGES_PER_WINDOW: epw_reg    <= cfg_value[EPW_BITS-1:0];
                REG_CLOCK_HZ:         clk_hz_reg <= cfg_value;
                default:              ;
            endcase
        end
    end

    // tick, wrap and edge counting for one accepted word
    assign tick_inc    = tick_count_reg + 1'b1;
    assign wrap_step   = (tick_inc == '0) && (wrap_count_reg != WRAP_MAX);
    assign wrap_new    = wrap_step ? wrap_count_reg + 1'b1 : wrap_count_reg;
    assign timeout_now = wrap_step && (wrap_new == WRAP_MAX) && !reported_reg;
    assign close_now   = in_edge && (edge_count_reg >= epw_reg);
    assign tick_event  = in_accept && !in_cmd;

    always_comb
    begin
        tick_count_next    = tick_count_reg;
        wrap_count_next    = wrap_count_reg;
        edge_count_next    = edge_count_reg;
        latched_total_next = latched_total_reg;
        reported_next      = reported_reg;
        if (in_accept)
        begin
            if (in_cmd)
            begin
                tick_count_next    = '0;
                wrap_count_next    = '0;
                edge_count_next    = '0;
                latched_total_next = '0;
                reported_next      = 1'b0;
            end
            else if (close_now)
            begin
                latched_total_next = {wrap_new, tick_inc};
                tick_count_next    = '0;
                wrap_count_next    = '0;
                edge_count_next    = '0;
                reported_next      = 1'b0;
            end
            else
            begin
                tick_count_next = tick_inc;
                wrap_count_next = wrap_new;
                if (in_edge)
                begin
                    edge_count_next = edge_count_reg + 1'b1;
                end
                if (timeout_now)
                begin
                    reported_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg    <= '0;
            wrap_count_reg    <= '0;
            edge_count_reg    <= '0;
            latched_total_reg <= '0;
            reported_reg      <= 1'b0;
        end
        else
        begin
            tick_count_reg    <= tick_count_next;
            wrap_count_reg    <= wrap_count_next;
            edge_count_reg    <= edge_count_next;
            latched_total_reg <= latched_total_next;
            reported_reg      <= reported_next;
        end
    end

    // divider operands: total over edge count, then ten times clock over period
    assign n_edges   = N_BITS'(epw_reg) + 1'b1;
    assign clk_ext   = SCALED_BITS'(clk_hz_reg);
    assign scaled_hz = (clk_ext << 3) + (clk_ext << 1);
    assign div_start = ctrl_cmd.div_n_start || ctrl_cmd.div_f_start;

    always_comb
    begin
        if (ctrl_cmd.div_n_start)
        begin
            div_dividend = DVD_BITS'(latched_total_reg);
            div_divisor  = DVS_BITS'(n_edges);
        end
        else
        begin
            div_dividend = DVD_BITS'(scaled_hz);
            div_divisor  = div_quot[DVS_BITS-1:0];
        end
    end

    rfm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign quot_over = (div_quot >> FREQ_BITS) != '0;

    // result staging
    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.load_timeout)
        begin
            res_freq_reg      <= '0;
            res_no_signal_reg <= 1'b1;
            res_clipped_reg   <= 1'b0;
        end
        else if (ctrl_cmd.load_zero)
        begin
            res_freq_reg      <= FREQ_MAX;
            res_no_signal_reg <= 1'b0;
            res_clipped_reg   <= 1'b1;
        end
        else if (ctrl_cmd.load_freq)
        begin
            res_freq_reg      <= quot_over ? FREQ_MAX : div_quot[FREQ_BITS-1:0];
            res_no_signal_reg <= 1'b0;
            res_clipped_reg   <= quot_over;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl_cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.push)
        begin
            out_freq_reg      <= res_freq_reg;
            out_no_signal_reg <= res_no_signal_reg;
            out_clipped_reg   <= res_clipped_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_freq      = out_freq_reg;
    assign out_no_signal = out_no_signal_reg;
    assign out_clipped   = out_clipped_reg;

    // status back to the controller
    assign ctrl_status.close     = tick_event && close_now;
    assign ctrl_status.timeout   = tick_event && timeout_now && !close_now;
    assign ctrl_status.div_done  = div_done && !div_busy;
    assign ctrl_status.quot_zero = (div_quot == '0);
    assign ctrl_status.out_free  = !out_valid_reg || out_ready;

    `RFM_ASSERT_IMPLY(a_reported_sat, clk, rst_n, reported_reg, wrap_count_reg == WRAP_MAX)
    `RFM_ASSERT_IMPLY(a_push_free, clk, rst_n, ctrl_cmd.push, !out_valid_reg || out_ready)
    `RFM_ASSERT_NEXT(a_restart_clear, clk, rst_n, in_accept && in_cmd,
        (tick_count_reg == '0) && (wrap_count_reg == '0) && (edge_count_reg == '0) && !reported_reg)

endmodule

`default_nettype wire

[src/rfm_ctrl.sv]
`default_nettype none

module rfm_ctrl
    import rfm_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ctrl_status_t  ctrl_status,
    output ctrl_cmd_t          ctrl_cmd,
    output logic               in_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START_N,
        S_DIV_N,
        S_DIV_F,
        S_PUSH
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;

    // sequencing of one window close or timeout
    always_comb
    begin
        state_next = state_reg;
        ctrl_cmd   = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (ctrl_status.close)
                begin
                    state_next = S_START_N;
                end
                else if (ctrl_status.timeout)
                begin
                    ctrl_cmd.load_timeout = 1'b1;
                    state_next            = S_PUSH;
                end
            end
            S_START_N:
            begin
                ctrl_cmd.div_n_start = 1'b1;
                state_next           = S_DIV_N;
            end
            S_DIV_N:
            begin
                if (ctrl_status.div_done)
                begin
                    if (ctrl_status.quot_zero)
                    begin
                        ctrl_cmd.load_zero = 1'b1;
                        state_next         = S_PUSH;
                    end
                    else
                    begin
                        ctrl_cmd.div_f_start = 1'b1;
                        state_next           = S_DIV_F;
                    end
                end
            end
            S_DIV_F:
            begin
                if (ctrl_status.div_done)
                begin
                    ctrl_cmd.load_freq = 1'b1;
                    state_next         = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (ctrl_status.out_free)
                begin
                    ctrl_cmd.push = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        in_ready_next = (state_next == S_IDLE);
    end

    // state and input ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready = in_ready_reg;

endmodule

`default_nettype wire

[src/reciprocal_frequency_meter_top.sv]
`default_nettype none

// reciprocal frequency meter
// input stream: one word per measurement clock tick; tuser is the command
//   (0 = tick, 1 = restart and clear counters), tdata bit 0 flags a qualified
//   rising edge on that tick. ticks are taken one per cycle while no result
//   is being worked out.
// output stream: frequency in tenths of a hertz with no_signal and clipped
//   flags in tuser. a window close word takes two passes of the shared
//   one-bit-per-cycle divider, 30 steps each, before the output register,
//   or one pass and a clipped word when the edge period is zero; input
//   ready is low meanwhile. a timeout word is staged in the result register
//   and then pushed to the output register.
// config channel: index 0 = edges_per_window, 1 = clock_hz; always ready.
//   write only while the meter is idle.
// reset: counters and latched total clear, edges_per_window = 64,
//   clock_hz = 16000000, output empty.
// stall: a result holds in the output register; the meter keeps taking ticks
//   until the next result is ready and then waits for the register to drain.
module reciprocal_frequency_meter_top
    import rfm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [7:0]          s_axis_tdata,   // [0] edge_req, [7:1] zero
    input  wire logic                s_axis_tuser,   // [0] cmd
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [FREQ_BITS-1:0]     m_axis_tdata,   // [15:0] frequency_tenths
    output logic [1:0]               m_axis_tuser,   // [0] no_signal, [1] clipped
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [0:0]          cfg_index,
    input  wire logic [CLK_BITS-1:0] cfg_data
);

    ctrl_cmd_t    ctrl_cmd;
    ctrl_status_t ctrl_status;
    logic         in_accept;
    logic         cfg_we;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    rfm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_accept     (in_accept),
        .in_cmd        (s_axis_tuser),
        .in_edge       (s_axis_tdata[0]),
        .cfg_we        (cfg_we),
        .cfg_sel       (cfg_reg_t'(cfg_index)),
        .cfg_value     (cfg_data),
        .ctrl_cmd      (ctrl_cmd),
        .ctrl_status   (ctrl_status),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .out_freq      (m_axis_tdata),
        .out_no_signal (m_axis_tuser[0]),
        .out_clipped   (m_axis_tuser[1])
    );

    rfm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl_status (ctrl_status),
        .ctrl_cmd    (ctrl_cmd),
        .in_ready    (s_axis_tready)
    );

endmodule

`default_nettype wire

[tb/sv/reciprocal_frequency_meter_checker.sv]
module reciprocal_frequency_meter_checker
    import rfm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    input  wire logic                s_axis_tready,
    input  wire logic [7:0]          s_axis_tdata,   // [0] edge_req, [7:1] zero
    input  wire logic                s_axis_tuser,   // [0] cmd
    input  wire logic                m_axis_tvalid,
    input  wire logic                m_axis_tready,
    input  wire logic [FREQ_BITS-1:0] m_axis_tdata,  // [15:0] frequency_tenths
    input  wire logic [1:0]          m_axis_tuser,   // [0] no_signal, [1] clipped
    input  wire logic                cfg_valid,
    input  wire logic                cfg_ready,
    input  wire logic [0:0]          cfg_index,
    input  wire logic [CLK_BITS-1:0] cfg_data,
    output int                       mismatches,
    output int                       readings_due,
    output int                       windows_seen,
    output int                       clipped_seen,
    output int                       no_signal_seen
);

    typedef struct packed {
        logic [FREQ_BITS-1:0] freq;
        logic                 no_signal;
        logic                 clipped;
    } reading_t;

    // readings predicted but not yet seen on the output
    reading_t pending_readings[$];

    // shadow configuration
    logic [EPW_BITS-1:0]   epw;
    logic [CLK_BITS-1:0]   hz;

    // shadow measurement state
    logic [TICK_BITS-1:0]  ticks;
    logic [WRAP_BITS-1:0]  wraps;
    logic [7:0]            edges;
    logic [TOTAL_BITS-1:0] total;
    logic                  timeout_done;

    always @(posedge clk or negedge rst_n)
    begin : watch
        reading_t        got;
        reading_t        want;
        reading_t        calc;
        logic            timeout_now;
        longint unsigned span;
        longint unsigned per_edge;
        longint unsigned quotient;

        if (!rst_n)
        begin
            epw            = EPW_RESET;
            hz             = CLK_RESET;
            ticks          = '0;
            wraps          = '0;
            edges          = '0;
            total          = '0;
            timeout_done   = 1'b0;
            pending_readings.delete();
            mismatches     = 0;
            readings_due   = 0;
            windows_seen   = 0;
            clipped_seen   = 0;
            no_signal_seen = 0;
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_EDGES_PER_WINDOW: epw = cfg_data[EPW_BITS-1:0];
                    REG_CLOCK_HZ:         hz  = cfg_data;
                endcase
            end

            // compare an output word with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]};
                if (pending_readings.size() == 0)
                begin
                    $error("output word with nothing expected: frequency_tenths %0d",
                           got.freq);
                    mismatches++;
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (got.freq !== want.freq)
                    begin
                        $error("frequency_tenths: expected %0d, got %0d", want.freq, got.freq);
                        mismatches++;
                    end
                    if (got.no_signal !== want.no_signal)
                    begin
                        $error("no_signal: expected %0d, got %0d",
                               want.no_signal, got.no_signal);
                        mismatches++;
                    end
                    if (got.clipped !== want.clipped)
                    begin
                        $error("clipped: expected %0d, got %0d", want.clipped, got.clipped);
                        mismatches++;
                    end
                    if (want.no_signal)
                        no_signal_seen++;
                    else
                        windows_seen++;
                    if (want.clipped)
                        clipped_seen++;
                end
            end

            // advance the shadow meter by one input word
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser)
                begin
                    ticks        = '0;
                    wraps        = '0;
                    edges        = '0;
                    total        = '0;
                    timeout_done = 1'b0;
                end
                else
                begin
                    timeout_now = 1'b0;
                    ticks = ticks + 1'b1;
                    if (ticks == '0 && wraps != WRAP_MAX)
                    begin
                        wraps = wraps + 1'b1;
                        if (wraps == WRAP_MAX && !timeout_done)
                            timeout_now = 1'b1;
                    end

                    if (s_axis_tdata[0] && edges >= epw)
                    begin
                        // window closes, counters restart
                        total        = {wraps, ticks};
                        ticks        = '0;
                        wraps        = '0;
                        edges        = '0;
                        timeout_done = 1'b0;
                        span     = total;
                        per_edge = epw;
                        per_edge = span / (per_edge + 1);
                        calc.no_signal = 1'b0;
                        if (per_edge == 0)
                        begin
                            calc.freq    = FREQ_MAX;
                            calc.clipped = 1'b1;
                        end
                        else
                        begin
                            quotient = hz;
                            quotient = (quotient * 10) / per_edge;
                            calc.clipped = (quotient > FREQ_MAX);
                            calc.freq    = calc.clipped ? FREQ_MAX : quotient[FREQ_BITS-1:0];
                        end
                        pending_readings.push_back(calc);
                    end
                    else
                    begin
                        if (s_axis_tdata[0])
                            edges = edges + 1'b1;
                        // no-signal word once per saturation
                        if (timeout_now)
                        begin
                            timeout_done   = 1'b1;
                            calc.freq      = '0;
                            calc.no_signal = 1'b1;
                            calc.clipped   = 1'b0;
                            pending_readings.push_back(calc);
                        end
                    end
                end
            end

            readings_due = pending_readings.size();
        end
    end

endmodule

[tb/sv/reciprocal_frequency_meter_top_test.sv]
module reciprocal_frequency_meter_top_test;
    import rfm_pkg::*;

    localparam longint CYCLE_LIMIT   = 400_000;
    localparam int     SETTLE_CYCLES = 100;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = 8'd0;   // [0] edge_req, [7:1] zero
    logic                 s_axis_tuser  = 1'b0;   // [0] cmd
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [FREQ_BITS-1:0] m_axis_tdata;           // [15:0] frequency_tenths
    logic [1:0]           m_axis_tuser;           // [0] no_signal, [1] clipped
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [0:0]           cfg_index     = 1'b0;
    logic [CLK_BITS-1:0]  cfg_data      = '0;

    int     mismatches;
    int     readings_due;
    int     windows_seen;
    int     clipped_seen;
    int     no_signal_seen;
    int     tx_idle_pct     = 36;
    int     rx_idle_pct     = 54;
    int     words_sent      = 0;
    int     restarts_sent   = 0;
    longint cycles          = 0;

    reciprocal_frequency_meter_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    reciprocal_frequency_meter_checker reading_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .readings_due   (readings_due),
        .windows_seen   (windows_seen),
        .clipped_seen   (clipped_seen),
        .no_signal_seen (no_signal_seen)
    );

    // clock
    always #10 clk = ~clk;

    // receiver stalls
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one input word, with random idle cycles ahead of it
    task automatic send_word(input logic restart, input logic edge_flag);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= restart;
        s_axis_tdata  <= {7'd0, edge_flag};
        do @(posedge clk); while (!s_axis_tready);
        words_sent++;
        if (restart)
            restarts_sent++;
    endtask

    // hold the input until every predicted reading is out, then let it settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (readings_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write both registers while the meter is idle
    task automatic configure(input logic [EPW_BITS-1:0] epw, input logic [CLK_BITS-1:0] hz);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= REG_EDGES_PER_WINDOW;
        cfg_data  <= CLK_BITS'(epw);
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= REG_CLOCK_HZ;
        cfg_data  <= hz;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int                  i;
        int                  seg;
        int                  seg_len;
        int                  period;
        int                  roll;
        int                  words_random;
        logic [EPW_BITS-1:0] epw_pick;
        logic [CLK_BITS-1:0] hz_pick;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: one window of 65 back-to-back edges
        send_word(1'b1, 1'b0);
        for (i = 0; i < 65; i++)
            send_word(1'b0, 1'b1);

        // single-edge windows at the fastest clock, quotient overflows
        configure(8'd0, 26'd50000000);
        send_word(1'b1, 1'b1);
        send_word(1'b0, 1'b1);
        send_word(1'b0, 1'b0);
        send_word(1'b0, 1'b0);
        send_word(1'b0, 1'b0);
        send_word(1'b0, 1'b1);

        // slowest clock, small quotients; restart in the middle of a window
        configure(8'd0, 26'd1);
        send_word(1'b0, 1'b1);
        send_word(1'b0, 1'b0);
        send_word(1'b0, 1'b1);
        send_word(1'b0, 1'b0);
        send_word(1'b0, 1'b0);
        send_word(1'b1, 1'b0);
        send_word(1'b0, 1'b1);

        // random windows with varied edge spacing and configuration
        seg = 0;
        words_random = 0;
        while (words_random < 520)
        begin
            if (seg == 1)
                epw_pick = 8'd254;
            else if (seg == 3)
                epw_pick = 8'd0;
            else if ($urandom_range(9) == 0)
                epw_pick = EPW_BITS'($urandom_range(254, 8));
            else
                epw_pick = EPW_BITS'($urandom_range(7));
            case ($urandom_range(3))
                0:       hz_pick = 26'd1;
                1:       hz_pick = 26'd50000000;
                2:       hz_pick = CLK_BITS'($urandom_range(200000, 1));
                default: hz_pick = CLK_BITS'($urandom_range(50000000, 1));
            endcase
            configure(epw_pick, hz_pick);

            // wide windows get dense edges and no restarts
            if (epw_pick >= 16)
            begin
                seg_len = epw_pick + 41;
                period  = 1;
            end
            else
            begin
                seg_len = 100;
                period  = $urandom_range(4, 1);
            end

            for (i = 0; i < seg_len && words_random < 520; i++)
            begin
                // idle pattern follows the number of random words sent
                if (words_random == 170)
                begin
                    tx_idle_pct = 54;
                    rx_idle_pct = 36;
                end
                else if (words_random == 345)
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                roll = $urandom_range(99);
                if (roll < 2 && epw_pick < 16)
                    send_word(1'b1, 1'($urandom_range(1)));
                else if (roll < 10)
                    send_word(1'b0, 1'($urandom_range(1)));
                else
                    send_word(1'b0, $urandom_range(period - 1) == 0);
                words_random++;
                if ($urandom_range(199) == 0)
                    wait_drained();
            end
            seg++;
        end

        wait_drained();
        @(negedge clk);
        $display("covered %0d input words including %0d restarts", words_sent, restarts_sent);
        $display("checked %0d window readings (%0d clipped) and %0d no-signal readings",
                 windows_seen, clipped_seen, no_signal_seen);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/rfm_pkg.sv
src/rfm_div.sv
src/rfm_datapath.sv
src/rfm_ctrl.sv
src/reciprocal_frequency_meter_top.sv
tb/sv/reciprocal_frequency_meter_checker.sv
tb/sv/reciprocal_frequency_meter_top_test.sv
